// ----- rtl/core/stream_find_replace_unit_macros.svh -----
// Assertion macros for the find-and-replace unit.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef STREAM_FIND_REPLACE_UNIT_MACROS_SVH
`define STREAM_FIND_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define SFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sfr_pkg.sv -----
package sfr_pkg;

    // Window geometry
    localparam int MAX_PAT_BYTES = 8;
    localparam int CNT_W         = $clog2(MAX_PAT_BYTES + 1);
    localparam int IDX_W         = $clog2(MAX_PAT_BYTES);
    localparam int PAT_W         = 64;
    localparam int LEN_W         = 4;
    localparam int REPL_MAX      = 8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SEARCH_PAT  = 2'd0,
        REG_SEARCH_LEN  = 2'd1,
        REG_REPL_PAT    = 2'd2,
        REG_REPL_LEN    = 2'd3
    } t_reg_idx;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REPL,
        ST_FLUSH,
        ST_MARK
    } t_state;

    // Source of an output word
    typedef enum logic [1:0] {
        EMIT_WIN,
        EMIT_REPL,
        EMIT_MARK
    } t_emit_sel;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      clear_count;
        logic      shift;
        logic      idx_clr;
        logic      idx_inc;
        logic      emit;
        t_emit_sel emit_sel;
        logic      eor;
        logic      eos;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic count_ge_slen;
        logic match;
        logic rlen_zero;
        logic repl_final;
        logic count_is_one;
        logic count_gt_one;
        logic last_flag;
    } t_status;

endpackage

// ----- rtl/core/sfr_datapath.sv -----
module sfr_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [sfr_pkg::PAT_W-1:0]   i_cfg_wdata,
    // source word
    input  logic [7:0]                  i_byte,
    input  logic                        i_last,
    // result word
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [7:0]                  o_out_byte,
    output logic                        o_out_bv,
    output logic                        o_out_eos,
    output logic                        o_out_eor,
    // control
    input  sfr_pkg::t_cmd               i_cmd,
    output sfr_pkg::t_status            o_status
);
    import sfr_pkg::*;

    // Configuration registers
    logic [PAT_W-1:0] r_pat;
    logic [LEN_W-1:0] r_slen;
    logic [PAT_W-1:0] r_rpat;
    logic [LEN_W-1:0] r_rlen;

    // Pending window, oldest byte at entry 0
    logic [7:0]       r_win [MAX_PAT_BYTES];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_last;
    logic [IDX_W-1:0] r_idx;

    // Output register
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_bv;
    logic             r_out_eos;
    logic             r_out_eor;

    logic [CNT_W-1:0] slen_eff;
    logic [CNT_W-1:0] rlen_eff;
    logic [IDX_W-1:0] app_idx;
    logic             match;
    logic [7:0]       emit_byte;
    logic             emit_bv;
    logic             out_free;

    // Effective lengths, clamped into range
    always_comb begin
        if (r_slen == '0) begin
            slen_eff = CNT_W'(1);
        end else if (CNT_W'(r_slen) > CNT_W'(MAX_PAT_BYTES)) begin
            slen_eff = CNT_W'(MAX_PAT_BYTES);
        end else begin
            slen_eff = CNT_W'(r_slen);
        end
        if (CNT_W'(r_rlen) > CNT_W'(REPL_MAX)) begin
            rlen_eff = CNT_W'(REPL_MAX);
        end else begin
            rlen_eff = CNT_W'(r_rlen);
        end
    end

    // Append slot, clamped to the top entry
    assign app_idx = (r_count > CNT_W'(MAX_PAT_BYTES - 1)) ? IDX_W'(MAX_PAT_BYTES - 1)
                                                           : r_count[IDX_W-1:0];

    // Per-entry compare against the pattern; unused entries pass
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < MAX_PAT_BYTES; i++) begin
            if ((CNT_W'(i) < slen_eff) && (r_win[i] != r_pat[8*i +: 8])) begin
                match = 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Output word source
    always_comb begin
        case (i_cmd.emit_sel)
            EMIT_WIN: begin
                emit_byte = r_win[0];
                emit_bv   = 1'b1;
            end
            EMIT_REPL: begin
                emit_byte = r_rpat[8*r_idx +: 8];
                emit_bv   = 1'b1;
            end
            EMIT_MARK: begin
                emit_byte = 8'd0;
                emit_bv   = 1'b0;
            end
            default: begin
                emit_byte = 8'd0;
                emit_bv   = 1'b0;
            end
        endcase
    end

    // Status back to the controller
    always_comb begin
        o_status.out_free      = out_free;
        o_status.count_ge_slen = (r_count >= slen_eff);
        o_status.match         = match;
        o_status.rlen_zero     = (rlen_eff == '0);
        o_status.repl_final    = ((CNT_W'(r_idx) + CNT_W'(1)) == rlen_eff);
        o_status.count_is_one  = (r_count == CNT_W'(1));
        o_status.count_gt_one  = (r_count > CNT_W'(1));
        o_status.last_flag     = r_last;
    end

    // Fill count next value
    always_comb begin
        n_count = r_count;
        if (i_cfg_we && (t_reg_idx'(i_cfg_idx) == REG_SEARCH_LEN)) begin
            n_count = '0;
        end else if (i_cmd.clear_count) begin
            n_count = '0;
        end else if (i_cmd.load) begin
            n_count = CNT_W'(app_idx) + CNT_W'(1);
        end else if (i_cmd.shift) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat       <= '0;
            r_slen      <= LEN_W'(1);
            r_rpat      <= '0;
            r_rlen      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SEARCH_PAT: r_pat  <= i_cfg_wdata;
                    REG_SEARCH_LEN: r_slen <= i_cfg_wdata[LEN_W-1:0];
                    REG_REPL_PAT:   r_rpat <= i_cfg_wdata;
                    REG_REPL_LEN:   r_rlen <= i_cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: window, flags, replacement index, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[app_idx] <= i_byte;
            r_last         <= i_last;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < MAX_PAT_BYTES - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_byte <= emit_byte;
            r_out_bv   <= emit_bv;
            r_out_eos  <= i_cmd.eos;
            r_out_eor  <= i_cmd.eor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_bv    = r_out_bv;
    assign o_out_eos   = r_out_eos;
    assign o_out_eor   = r_out_eor;

endmodule

// ----- rtl/core/sfr_ctrl.sv -----
module sfr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sfr_pkg::t_status   i_status,
    output sfr_pkg::t_cmd      o_cmd,
    output sfr_pkg::t_state    o_state
);
    import sfr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.count_ge_slen) begin
                    if (i_status.match) begin
                        o_cmd.clear_count = 1'b1;
                        o_cmd.idx_clr     = 1'b1;
                        if (!i_status.rlen_zero) begin
                            n_state = ST_REPL;
                        end else if (i_status.last_flag) begin
                            n_state = ST_MARK;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else if (i_status.out_free) begin
                        // slide by one, oldest byte out
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_WIN;
                        o_cmd.shift    = 1'b1;
                        o_cmd.eor      = !i_status.last_flag || i_status.count_is_one;
                        o_cmd.eos      = i_status.last_flag && i_status.count_is_one;
                        if (i_status.last_flag && i_status.count_gt_one) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end else if (i_status.last_flag) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_REPL: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_REPL;
                    o_cmd.idx_inc  = 1'b1;
                    o_cmd.eor      = i_status.repl_final;
                    o_cmd.eos      = i_status.repl_final && i_status.last_flag;
                    if (i_status.repl_final) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_WIN;
                    o_cmd.shift    = 1'b1;
                    o_cmd.eor      = i_status.count_is_one;
                    o_cmd.eos      = i_status.count_is_one;
                    if (i_status.count_is_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MARK: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_MARK;
                    o_cmd.eor      = 1'b1;
                    o_cmd.eos      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

// ----- rtl/core/stream_find_replace_unit.sv -----
// Channel   Dir  Width   Contents
// s_*       in   8+1     tdata: in_byte[7:0]; tlast: in_last
// m_*       out  8+1+2   tdata: out_byte[7:0]; tlast: end_of_stream;
//                        tuser: byte_valid[0], end_of_run[1]
// cfg_*     in   1+2+64  write enable, register index, write data
//
// One word at a time; s_tready is high only in the idle state. The accepted word is
// evaluated in the state after the accept, which emits a slid-out byte if any;
// words emitted after it (replacement, flush, bare end marker) come from their own states.
// Synchronous active-low reset clears state, fill count, output valid and configuration,
// except search length, which resets to one; window bytes are undefined until written.
// A full output register not drained by m_tready stalls any emitting state.
module stream_find_replace_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [sfr_pkg::PAT_W-1:0]   i_cfg_wdata,
    // source stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] in_byte
    input  logic                        i_s_tlast,   // in_last
    // result stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,   // [7:0] out_byte
    output logic                        o_m_tlast,   // end_of_stream
    output logic [1:0]                  o_m_tuser    // [0] byte_valid, [1] end_of_run
);
    import sfr_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_state  state;
    logic    out_bv;
    logic    out_eor;
    logic    s_take;
    logic    marker_ok;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    sfr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (o_m_tdata),
        .o_out_bv    (out_bv),
        .o_out_eos   (o_m_tlast),
        .o_out_eor   (out_eor),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    assign o_m_tuser = {out_eor, out_bv};

    // helpers for the checks below
    assign s_take    = i_s_tvalid && o_s_tready;
    assign marker_ok = (o_m_tdata == 8'd0) && o_m_tlast && out_eor;

`include "stream_find_replace_unit_macros.svh"

    // a bare end marker carries a zero byte and closes both run and stream
    `SFR_ASSERT_IMPL(a_marker_form, o_m_tvalid && !out_bv, marker_ok, "end marker malformed")
    // end of stream is always the end of a run
    `SFR_ASSERT_IMPL(a_eos_is_eor, o_m_tvalid && o_m_tlast, out_eor, "eos without eor")
    // one word in flight: after an accept the source side is closed
    `SFR_ASSERT_NEXT(a_one_in_flight, s_take, !o_s_tready && (state == ST_EVAL), "busy accept")

endmodule
